>>> rtl/psds_pkg.sv
`timescale 1ns / 1ps
package psds_pkg;

	localparam int DEF_MAX_PRIMITIVES = 16;
	localparam int VOXEL_W = 20;
	localparam int COUNT_W = 5;
	localparam int POS_W = 53;    // 32-bit index times 20-bit voxel size, signed
	localparam int MAG_W = 54;    // magnitude of position minus center
	localparam int ACC_W = 66;    // sum of three 64-bit squares
	localparam int REM_W = 35;
	localparam int ROOT_STEPS = 32;
	localparam logic signed [31:0] DIST_MAX = 32'sh7FFF_FFFF;

	typedef enum logic [1:0] {
		SHAPE_SPHERE = 2'd0,
		SHAPE_BOX    = 2'd1,
		SHAPE_SLAB   = 2'd2,
		SHAPE_BAD    = 2'd3
	} shape_t;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_BAD_SHAPE = 3'd1,
		STAT_EMPTY_MAT = 3'd2,
		STAT_BAD_SIZE  = 3'd3,
		STAT_OVERFLOW  = 3'd4
	} status_t;

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_EVAL = 1'b1
	} req_t;

	typedef struct packed {
		logic              req_type;
		logic [3:0]        slot;
		logic [1:0]        shape;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
		logic [30:0]       size_x;
		logic [30:0]       size_y;
		logic [30:0]       size_z;
		logic [7:0]        priority_req;
		logic [7:0]        material;
	} in_t;

	typedef struct packed {
		logic signed [31:0] signed_distance;
		logic [7:0]        hit_material;
		logic [3:0]        hit_slot;
		logic              any_selected;
		logic [2:0]        status;
	} out_t;

	typedef struct packed {
		logic [1:0]        shape;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic [30:0]       ex;
		logic [30:0]       ey;
		logic [30:0]       ez;
		logic [7:0]        pri;
		logic [7:0]        mat;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_POS,
		ST_READ,
		ST_DIFF,
		ST_PREP,
		ST_SQ,
		ST_ROOT_INIT,
		ST_ROOT,
		ST_DIST,
		ST_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic       capture;
		logic       load_wr;
		logic       pos;
		logic       rd;
		logic       diff;
		logic       prep;
		logic       sq;
		logic       root_init;
		logic       root_step;
		logic       dist_calc;
		logic       cmp;
		logic       res_wr;
		logic [1:0] sel;
	} cmd_t;

endpackage

>>> rtl/primitive_set_distance_select.sv
`timescale 1ns / 1ps
// Primitive-set signed distance selector. Holds a table of up to MAX_PRIMITIVES
// spheres, boxes and ground slabs. A load transaction checks an entry and writes
// it (status reports empty material, bad shape or nonpositive size); an evaluate
// transaction scales the sample index by voxel_size and returns the minimum Q20.12
// signed distance over the first primitive_count entries (at most MAX_PRIMITIVES),
// with material and slot of the winner (ties: higher priority, then lower slot).
// One transaction is worked at a time. Each active entry passes in turn through
// the shared 32-step square root (one result bit per cycle) after its three
// components are squared on one 32x32 multiplier. A finished result waits in the
// output register while the next transaction is accepted. Registers: voxel_size
// at byte address 0, primitive_count at 4.
module primitive_set_distance_select import psds_pkg::*; #(
	parameter int MAX_PRIMITIVES = DEF_MAX_PRIMITIVES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_item,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_item,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IW = $clog2(MAX_PRIMITIVES + 1);

	logic [VOXEL_W-1:0] voxel_size_q;
	logic [COUNT_W-1:0] count_q;
	logic cfg_wr;
	cmd_t cmd;
	logic [IW-1:0] addr;

	// register file: word index is paddr[2]
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = paddr[2] ? 32'(count_q) : 32'(voxel_size_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voxel_size_q <= VOXEL_W'(4096);
			count_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[2])
				count_q <= pwdata[COUNT_W-1:0];
			else
				voxel_size_q <= pwdata[VOXEL_W-1:0];
		end
	end

	// the controller sees the request kind straight from the port at accept
	psds_ctrl #(.MAX_PRIMITIVES(MAX_PRIMITIVES)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_is_eval(in_item.req_type),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.primitive_count(count_q),
		.cmd(cmd),
		.addr(addr)
	);

	psds_datapath #(.MAX_PRIMITIVES(MAX_PRIMITIVES)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_item(in_item),
		.voxel_size(voxel_size_q),
		.cmd(cmd),
		.addr(addr),
		.out_item(out_item)
	);

endmodule

>>> rtl/psds_ctrl.sv
`timescale 1ns / 1ps
module psds_ctrl import psds_pkg::*; #(
	parameter int MAX_PRIMITIVES = DEF_MAX_PRIMITIVES,
	localparam int IW = $clog2(MAX_PRIMITIVES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               in_is_eval,
	output logic               out_valid,
	input  logic               out_stall,
	input  logic [COUNT_W-1:0] primitive_count,
	output cmd_t               cmd,
	output logic [IW-1:0]      addr
);

	state_t state_q, state_d;
	logic [4:0] step_q, step_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [IW-1:0] count_n;
	logic out_valid_q;
	logic in_take;

	assign count_n = (32'(primitive_count) > 32'(MAX_PRIMITIVES)) ?
		IW'(MAX_PRIMITIVES) : IW'(primitive_count);
	assign in_stall = (state_q != ST_IDLE);
	assign in_take = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign addr = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q <= step_d;
			idx_q <= idx_d;
			if (cmd.res_wr)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		step_d = step_q;
		idx_d = idx_q;
		cmd = '0;
		cmd.sel = step_q[1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					cmd.capture = 1'b1;
					step_d = '0;
					idx_d = '0;
					state_d = in_is_eval ? ST_POS : ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.load_wr = 1'b1;
				state_d = ST_DONE;
			end
			ST_POS: begin
				cmd.pos = 1'b1;
				step_d = step_q + 5'd1;
				if (step_q == 5'd2) begin
					step_d = '0;
					state_d = (count_n == '0) ? ST_DONE : ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd = 1'b1;
				state_d = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d = ST_SQ;
			end
			ST_SQ: begin
				cmd.sq = 1'b1;
				step_d = step_q + 5'd1;
				if (step_q == 5'd2) begin
					step_d = '0;
					state_d = ST_ROOT_INIT;
				end
			end
			ST_ROOT_INIT: begin
				cmd.root_init = 1'b1;
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				step_d = step_q + 5'd1;
				if (step_q == 5'(ROOT_STEPS - 1)) begin
					step_d = '0;
					state_d = ST_DIST;
				end
			end
			ST_DIST: begin
				cmd.dist_calc = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				idx_d = idx_q + 1'b1;
				state_d = (idx_q + 1'b1 < count_n) ? ST_READ : ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.res_wr = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> rtl/psds_datapath.sv
`timescale 1ns / 1ps
module psds_datapath import psds_pkg::*; #(
	parameter int MAX_PRIMITIVES = DEF_MAX_PRIMITIVES,
	localparam int IW = $clog2(MAX_PRIMITIVES + 1),
	localparam int AW = (MAX_PRIMITIVES > 1) ? $clog2(MAX_PRIMITIVES) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  in_t                in_item,
	input  logic [VOXEL_W-1:0] voxel_size,
	input  cmd_t               cmd,
	input  logic [IW-1:0]      addr,
	output out_t               out_item
);

	entry_t mem [MAX_PRIMITIVES];
	in_t req_q;
	entry_t ent_q;
	logic signed [POS_W-1:0] pos_q [3];
	logic [MAG_W-1:0] mag_q [3];
	logic [31:0] comp_q [3];
	logic big_q;
	logic signed [31:0] off_q;
	logic [ACC_W-1:0] acc_q;
	logic [63:0] src_q;
	logic [REM_W-1:0] rem_q;
	logic [31:0] root_q;
	logic ovf_q;
	logic signed [31:0] dist_q;
	logic dsat_q;
	logic any_q, satany_q;
	logic signed [31:0] best_d_q;
	logic [7:0] best_pri_q, best_mat_q;
	logic [3:0] best_slot_q;
	logic [2:0] ld_status_q;
	out_t res_q;
	out_t res_d;

	logic signed [31:0] idx_sel;
	logic signed [POS_W-1:0] prod;
	logic signed [31:0] cen [3];
	logic [30:0] ext [3];
	logic signed [MAG_W:0] dif [3];
	logic signed [MAG_W:0] q [3];
	logic [MAG_W-1:0] pa [3];
	logic signed [MAG_W:0] mx;
	logic [63:0] sq;
	logic [REM_W-1:0] rem_sh, trial;
	logic [32:0] len;
	logic signed [34:0] dfull;
	logic dsat;
	logic [2:0] ld_status;
	logic ld_ok;
	logic is_sphere;

	assign out_item = res_q;

	always_comb begin
		unique case (cmd.sel)
			2'd0: idx_sel = req_q.coord_x;
			2'd1: idx_sel = req_q.coord_y;
			default: idx_sel = req_q.coord_z;
		endcase
	end
	assign prod = POS_W'(idx_sel * $signed({1'b0, voxel_size}));

	assign cen[0] = ent_q.cx;
	assign cen[1] = ent_q.cy;
	assign cen[2] = ent_q.cz;
	assign ext[0] = ent_q.ex;
	assign ext[1] = ent_q.ey;
	assign ext[2] = ent_q.ez;
	assign is_sphere = (ent_q.shape == SHAPE_SPHERE);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dif[k] = (MAG_W + 1)'(pos_q[k]) - (MAG_W + 1)'(cen[k]);
			q[k] = $signed({1'b0, mag_q[k]}) - $signed((MAG_W + 1)'(ext[k]));
			if (is_sphere)
				pa[k] = mag_q[k];
			else
				pa[k] = q[k][MAG_W] ? '0 : q[k][MAG_W-1:0];
		end
		mx = q[0];
		if (q[1] > mx)
			mx = q[1];
		if (q[2] > mx)
			mx = q[2];
	end

	assign sq = comp_q[cmd.sel] * comp_q[cmd.sel];
	assign rem_sh = {rem_q[REM_W-3:0], src_q[63:62]};
	assign trial = REM_W'({root_q, 2'b01});
	assign len = {1'b0, root_q} + 33'(rem_q > REM_W'(root_q));
	assign dfull = $signed({2'b0, len}) + 35'(off_q);
	assign dsat = ovf_q || (dfull > 35'(DIST_MAX));

	always_comb begin
		ld_ok = 1'b0;
		if (req_q.material == '0)
			ld_status = STAT_EMPTY_MAT;
		else if (req_q.shape == SHAPE_BAD)
			ld_status = STAT_BAD_SHAPE;
		else if (req_q.size_x == '0 || (req_q.shape != SHAPE_SPHERE &&
				(req_q.size_y == '0 || req_q.size_z == '0)))
			ld_status = STAT_BAD_SIZE;
		else begin
			ld_status = STAT_OK;
			ld_ok = (32'(req_q.slot) < 32'(MAX_PRIMITIVES));
		end
	end

	// table storage
	always_ff @(posedge clk) begin
		if (cmd.load_wr && ld_ok)
			mem[AW'(req_q.slot)] <= '{shape: req_q.shape, cx: req_q.coord_x,
				cy: req_q.coord_y, cz: req_q.coord_z, ex: req_q.size_x,
				ey: req_q.size_y, ez: req_q.size_z, pri: req_q.priority_req,
				mat: req_q.material};
		if (cmd.rd)
			ent_q <= mem[addr[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			req_q <= in_item;
		if (cmd.load_wr)
			ld_status_q <= ld_status;
		if (cmd.pos)
			pos_q[cmd.sel] <= prod;
		if (cmd.diff)
			for (int k = 0; k < 3; k++)
				mag_q[k] <= dif[k][MAG_W] ? MAG_W'(-dif[k]) : dif[k][MAG_W-1:0];
		if (cmd.prep) begin
			big_q <= (pa[0][MAG_W-1:32] != '0) || (pa[1][MAG_W-1:32] != '0) ||
				(pa[2][MAG_W-1:32] != '0);
			for (int k = 0; k < 3; k++)
				comp_q[k] <= pa[k][31:0];
			if (is_sphere)
				off_q <= -$signed({1'b0, ent_q.ex});
			else
				off_q <= mx[MAG_W] ? mx[31:0] : '0;
		end
		if (cmd.sq)
			acc_q <= ((cmd.sel == 2'd0) ? '0 : acc_q) + ACC_W'(sq);
		if (cmd.root_init) begin
			src_q <= acc_q[63:0];
			ovf_q <= big_q || (acc_q[ACC_W-1:64] != '0);
			rem_q <= '0;
			root_q <= '0;
		end
		if (cmd.root_step) begin
			src_q <= {src_q[61:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q <= rem_sh - trial;
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				root_q <= {root_q[30:0], 1'b0};
			end
		end
		if (cmd.dist_calc) begin
			dist_q <= dsat ? DIST_MAX : dfull[31:0];
			dsat_q <= dsat;
		end
		if (cmd.cmp && (!any_q || dist_q < best_d_q ||
				(dist_q == best_d_q && ent_q.pri > best_pri_q))) begin
			best_d_q <= dist_q;
			best_pri_q <= ent_q.pri;
			best_mat_q <= ent_q.mat;
			best_slot_q <= 4'(addr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q <= 1'b0;
			satany_q <= 1'b0;
		end else if (cmd.capture) begin
			any_q <= 1'b0;
			satany_q <= 1'b0;
		end else if (cmd.cmp) begin
			any_q <= 1'b1;
			satany_q <= satany_q || dsat_q;
		end
	end

	always_comb begin
		res_d = '0;
		if (req_q.req_type == REQ_LOAD)
			res_d.status = ld_status_q;
		else if (any_q) begin
			res_d.signed_distance = best_d_q;
			res_d.hit_material = best_mat_q;
			res_d.hit_slot = best_slot_q;
			res_d.any_selected = 1'b1;
			res_d.status = satany_q ? STAT_OVERFLOW : STAT_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_wr)
			res_q <= res_d;
	end

endmodule

>>> rtl/psds_checker.sv
`timescale 1ns / 1ps
module psds_checker import psds_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input out_t out_item
);

	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// one transaction at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted a transaction while busy");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.any_selected |-> out_item.signed_distance == 0 &&
		out_item.hit_material == 0 && out_item.hit_slot == 0)
		else $error("nonzero fields without a selection");

	a_ovf_sel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == STAT_OVERFLOW |-> out_item.any_selected)
		else $error("overflow without a selection");

endmodule

bind primitive_set_distance_select psds_checker u_psds_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_item(out_item)
);

>>> sim/primitive_set_distance_select_tb.sv
`timescale 1ns / 1ps
module primitive_set_distance_select_tb;
	import psds_pkg::*;

	localparam int TABLE_DEPTH = 16;
	localparam logic [2:0] ADDR_VOXEL_SIZE = 3'd0;
	localparam logic [2:0] ADDR_PRIM_COUNT = 3'd4;
	localparam longint DIST_LIMIT = 64'sd2147483647;
	localparam int WATCHDOG_LIMIT = 20000;

	// Scoreboard: keeps its own copy of the primitive table and registers,
	// works out the selected distance of each accepted transaction, and
	// checks results in order against what it worked out.
	class distance_scoreboard;
		shape_t tbl_shape[TABLE_DEPTH];
		longint tbl_cx[TABLE_DEPTH], tbl_cy[TABLE_DEPTH], tbl_cz[TABLE_DEPTH];
		longint tbl_ex[TABLE_DEPTH], tbl_ey[TABLE_DEPTH], tbl_ez[TABLE_DEPTH];
		logic [7:0] tbl_pri[TABLE_DEPTH], tbl_mat[TABLE_DEPTH];
		longint voxel;
		int unsigned prim_count;
		out_t pending[$];
		int errors;

		function new();
			voxel = 4096;
			prim_count = 0;
			errors = 0;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				tbl_shape[i] = SHAPE_SPHERE;
				tbl_cx[i] = 0; tbl_cy[i] = 0; tbl_cz[i] = 0;
				tbl_ex[i] = 0; tbl_ey[i] = 0; tbl_ez[i] = 0;
				tbl_pri[i] = 0; tbl_mat[i] = 0;
			end
		endfunction

		function longint unsigned root64(longint unsigned n);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > n) b >>= 2;
			while (b != 0) begin
				if (n >= res + b) begin
					n -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		// Rounded length of a nonnegative vector; 0 when it cannot fit.
		function bit vec_length(longint a, longint b, longint c, output longint len);
			longint unsigned ua, ub, uc, r;
			logic [67:0] sum;
			len = 0;
			if (a >= 64'sd4294967296 || b >= 64'sd4294967296 || c >= 64'sd4294967296)
				return 0;
			ua = a; ub = b; uc = c;
			sum = 68'(ua * ua) + 68'(ub * ub) + 68'(uc * uc);
			if (sum[67:64] != 0) return 0;
			r = root64(sum[63:0]);
			if (sum[63:0] - r * r > r) r++;
			len = r;
			return 1;
		endfunction

		function longint abs64(longint v);
			return v < 0 ? -v : v;
		endfunction

		function longint entry_distance(int i, longint px, longint py, longint pz,
				inout bit sat);
			longint dx, dy, dz, qx, qy, qz, mx, len, d;
			dx = abs64(px - tbl_cx[i]);
			dy = abs64(py - tbl_cy[i]);
			dz = abs64(pz - tbl_cz[i]);
			if (tbl_shape[i] == SHAPE_SPHERE) begin
				if (!vec_length(dx, dy, dz, len)) begin
					sat = 1;
					return DIST_LIMIT;
				end
				d = len - tbl_ex[i];
			end else begin
				qx = dx - tbl_ex[i];
				qy = dy - tbl_ey[i];
				qz = dz - tbl_ez[i];
				mx = qx > qy ? qx : qy;
				if (qz > mx) mx = qz;
				if (!vec_length(qx > 0 ? qx : 0, qy > 0 ? qy : 0, qz > 0 ? qz : 0, len)) begin
					sat = 1;
					return DIST_LIMIT;
				end
				d = len + (mx < 0 ? mx : 0);
			end
			if (d > DIST_LIMIT) begin
				sat = 1;
				d = DIST_LIMIT;
			end
			return d;
		endfunction

		function void note_input(in_t t);
			out_t r;
			longint px, py, pz, d, best_d;
			int n, best;
			bit sat;
			r = '0;
			if (t.req_type == REQ_LOAD) begin
				if (t.material == 0) r.status = STAT_EMPTY_MAT;
				else if (t.shape == SHAPE_BAD) r.status = STAT_BAD_SHAPE;
				else if (t.size_x == 0 ||
						(t.shape != SHAPE_SPHERE && (t.size_y == 0 || t.size_z == 0)))
					r.status = STAT_BAD_SIZE;
				else begin
					tbl_shape[t.slot] = shape_t'(t.shape);
					tbl_cx[t.slot] = longint'(t.coord_x);
					tbl_cy[t.slot] = longint'(t.coord_y);
					tbl_cz[t.slot] = longint'(t.coord_z);
					tbl_ex[t.slot] = t.size_x;
					tbl_ey[t.slot] = t.size_y;
					tbl_ez[t.slot] = t.size_z;
					tbl_pri[t.slot] = t.priority_req;
					tbl_mat[t.slot] = t.material;
				end
			end else begin
				px = longint'(t.coord_x) * voxel;
				py = longint'(t.coord_y) * voxel;
				pz = longint'(t.coord_z) * voxel;
				n = prim_count > TABLE_DEPTH ? TABLE_DEPTH : prim_count;
				sat = 0;
				best = 0;
				best_d = 0;
				for (int i = 0; i < n; i++) begin
					d = entry_distance(i, px, py, pz, sat);
					if (i == 0 || d < best_d || (d == best_d && tbl_pri[i] > tbl_pri[best])) begin
						best = i;
						best_d = d;
					end
				end
				if (n > 0) begin
					r.signed_distance = best_d[31:0];
					r.hit_material = tbl_mat[best];
					r.hit_slot = best[3:0];
					r.any_selected = 1'b1;
					r.status = sat ? STAT_OVERFLOW : STAT_OK;
				end
			end
			pending.push_back(r);
		endfunction

		function void check_result(out_t got);
			out_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %p", got);
				return;
			end
			want = pending.pop_front();
			if (got.signed_distance !== want.signed_distance ||
					got.hit_material !== want.hit_material ||
					got.hit_slot !== want.hit_slot ||
					got.any_selected !== want.any_selected ||
					got.status !== want.status) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected dist %0d mat %0d slot %0d any %0b st %0d, got dist %0d mat %0d slot %0d any %0b st %0d",
						want.signed_distance, want.hit_material, want.hit_slot,
						want.any_selected, want.status, got.signed_distance,
						got.hit_material, got.hit_slot, got.any_selected, got.status);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	in_t in_item;
	out_t out_item;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;

	distance_scoreboard dist_sb;
	int sent_count;
	int idle_cycles;
	in_t last_geom;

	primitive_set_distance_select u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Monitor: note accepted transactions on both sides; the input side
	// goes first so a result can never outrun its own expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) dist_sb.note_input(in_item);
			if (out_valid && !out_stall) dist_sb.check_result(out_item);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Receiver: random stall, one long hold-off to back the block up,
	// and a later stretch that never stalls.
	initial begin
		int unsigned cyc;
		out_stall = 1'b0;
		cyc = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc >= 3000 && cyc < 3400) out_stall <= 1'b1;
			else if (cyc >= 8000 && cyc < 12000) out_stall <= 1'b0;
			else out_stall <= ($urandom_range(99) < 34);
		end
	end

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_VOXEL_SIZE) dist_sb.voxel = data[19:0];
		else dist_sb.prim_count = data[4:0];
	endtask

	// Change registers only with the block drained.
	task automatic reconfigure(int unsigned vox, int unsigned cnt);
		drain();
		repeat (10) @(posedge clk);
		apb_write(ADDR_VOXEL_SIZE, vox);
		apb_write(ADDR_PRIM_COUNT, cnt);
	endtask

	// Let the clock tick first so the monitor has noted the last accepted input.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (dist_sb.pending.size() != 0) @(posedge clk);
	endtask

	task automatic send(in_t t);
		// quiet window: no sender gaps
		if ((sent_count < 300 || sent_count > 450) && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= t;
		do @(posedge clk); while (in_stall);
		sent_count++;
	endtask

	function automatic int small_signed(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic in_t make_load(int unsigned slot, shape_t shp, int cx, int cy, int cz,
			int unsigned sx, int unsigned sy, int unsigned sz, int unsigned pri,
			int unsigned mat);
		in_t t;
		t = '0;
		t.req_type = REQ_LOAD;
		t.slot = 4'(slot);
		t.shape = shp;
		t.coord_x = cx; t.coord_y = cy; t.coord_z = cz;
		t.size_x = 31'(sx); t.size_y = 31'(sy); t.size_z = 31'(sz);
		t.priority_req = 8'(pri);
		t.material = 8'(mat);
		return t;
	endfunction

	function automatic in_t make_eval(int x, int y, int z);
		in_t t;
		t = '0;
		t.req_type = REQ_EVAL;
		t.coord_x = x; t.coord_y = y; t.coord_z = z;
		// junk in the unused fields
		t.slot = 4'($urandom);
		t.shape = 2'($urandom);
		t.size_x = 31'($urandom); t.size_y = 31'($urandom); t.size_z = 31'($urandom);
		t.priority_req = 8'($urandom);
		t.material = 8'($urandom);
		return t;
	endfunction

	function automatic in_t random_load();
		in_t t;
		int unsigned pick;
		pick = $urandom_range(99);
		t = make_load($urandom_range(15), shape_t'($urandom_range(2)),
			small_signed(64 << 12), small_signed(64 << 12), small_signed(64 << 12),
			$urandom_range(1, 20 << 12), $urandom_range(1, 20 << 12),
			$urandom_range(1, 20 << 12), $urandom_range(255), $urandom_range(1, 255));
		if (pick < 15) begin
			// same geometry as an earlier entry to force distance ties
			t.shape = last_geom.shape;
			t.coord_x = last_geom.coord_x; t.coord_y = last_geom.coord_y;
			t.coord_z = last_geom.coord_z;
			t.size_x = last_geom.size_x; t.size_y = last_geom.size_y;
			t.size_z = last_geom.size_z;
			if ($urandom_range(1)) t.priority_req = last_geom.priority_req;
		end else if (pick < 25) begin
			t.coord_x = $urandom; t.coord_y = $urandom; t.coord_z = $urandom;
			t.size_x = 31'($urandom); t.size_y = 31'($urandom); t.size_z = 31'($urandom);
			if (t.size_x == 0) t.size_x = 1;
			if (t.size_y == 0) t.size_y = 1;
			if (t.size_z == 0) t.size_z = 1;
		end else if (pick < 30) begin
			t.material = 0;
		end else if (pick < 35) begin
			t.shape = SHAPE_BAD;
		end else if (pick < 42) begin
			case ($urandom_range(2))
				0: t.size_x = 0;
				1: t.size_y = 0;
				default: t.size_z = 0;
			endcase
		end
		if (t.material != 0 && t.shape != SHAPE_BAD) last_geom = t;
		return t;
	endfunction

	function automatic in_t random_eval();
		if ($urandom_range(99) < 10) return make_eval($urandom, $urandom, $urandom);
		return make_eval(small_signed(100), small_signed(100), small_signed(100));
	endfunction

	initial begin
		int unsigned vox_list[12];
		int unsigned cnt_list[12];
		dist_sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sent_count = 0;
		idle_cycles = 0;
		last_geom = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: nothing active after reset, then the load checks.
		send(make_eval(0, 0, 0));
		send(make_load(0, SHAPE_BAD, 0, 0, 0, 5, 5, 5, 1, 0));   // empty material wins
		send(make_load(0, SHAPE_BAD, 0, 0, 0, 5, 5, 5, 1, 7));   // bad shape
		send(make_load(0, SHAPE_SPHERE, 0, 0, 0, 0, 5, 5, 1, 7)); // zero radius
		send(make_load(0, SHAPE_BOX, 0, 0, 0, 5, 0, 5, 1, 7));
		send(make_load(0, SHAPE_SLAB, 0, 0, 0, 5, 5, 0, 1, 7));
		// Fill the whole table before any evaluation reads it.
		send(make_load(0, SHAPE_SPHERE, 0, 0, 0, 4096, 0, 0, 3, 1)); // sphere ignores y/z
		send(make_load(1, SHAPE_BOX, 8192, 0, 0, 4096, 4096, 4096, 0, 2));
		send(make_load(2, SHAPE_SLAB, 0, -20480, 0, 32'h7FFF_FFFF, 4096, 32'h7FFF_FFFF,
			255, 255));
		send(make_load(3, SHAPE_SLAB, 0, -20480, 0, 32'h7FFF_FFFF, 4096, 32'h7FFF_FFFF,
			254, 3));                                                  // tie, lower priority
		send(make_load(4, SHAPE_SPHERE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			31'h7FFF_FFFF, 1, 1, 0, 4));
		for (int i = 5; i < TABLE_DEPTH; i++)
			send(make_load(i, SHAPE_SPHERE, 0, 0, 0, 4096, 4096, 4096, 3, 100 + i)); // ties slot 0
		reconfigure(4096, 16);
		send(make_eval(0, 0, 0));
		send(make_eval(2, 0, 0));
		send(make_eval(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
		send(make_eval(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		reconfigure(20'hFFFFF, 31);
		send(make_eval(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send(make_eval(-1, 1, -1));

		// Random phases, each under its own register setting.
		vox_list = '{4096, 1, 20'hFFFFF, 4096, 2048, 65536, 4096, 1, 4096, 300, 8192, 4096};
		cnt_list = '{4, 0, 16, 2, 31, 1, 3, 17, 5, 8, 2, 16};
		for (int p = 0; p < 12; p++) begin
			reconfigure(p == 3 ? $urandom_range(1, 20'hFFFFF) : vox_list[p], cnt_list[p]);
			for (int k = 0; k < 105; k++) begin
				if (p == 4 && k == 50) drain();   // sender waits for every result
				if ($urandom_range(99) < 40) send(random_load());
				else send(random_eval());
			end
		end

		drain();
		repeat (50) @(posedge clk);
		if (dist_sb.errors == 0 && dist_sb.pending.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/psds_pkg.sv
rtl/psds_ctrl.sv
rtl/psds_datapath.sv
rtl/primitive_set_distance_select.sv
rtl/psds_checker.sv
sim/primitive_set_distance_select_tb.sv
